// ===== rtl/mce_pkg.sv =====
// Package for the Morse character encoder: types, element codes, case fold
// and code table lookup. No dependencies.
package mce_pkg;
   localparam int DIT_LENGTH_BITS = 16;
   localparam int SAMPLE_BITS = 18;
   localparam int CHAR_BITS = 21;
   localparam int CODE_BITS = 14;
   localparam int COUNT_BITS = 3;

   typedef enum logic [1:0] {
      KIND_DIT = 2'd0,
      KIND_DAH = 2'd1,
      KIND_SPACE = 2'd2,
      KIND_GAP = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_DIT_LENGTH = 1'b0,
      CSR_UKR_I = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND,
      ST_GAP
   } state_type;

   // count of elements, pattern with first element in low bits
   typedef struct packed {
      logic                  hit;
      logic [COUNT_BITS-1:0] count;
      logic [CODE_BITS-1:0]  pattern;
   } code_type;

   function automatic logic [CHAR_BITS-1:0] fold_case(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] r;
      r = c;
      if (c == 21'h130) r = 21'h69;
      else if (c == 21'h212A) r = 21'h6B;
      else if (c == 21'h212B) r = 21'hE5;
      else if (c == 21'h2126) r = 21'h3C9;
      else if (c >= 21'h41 && c <= 21'h5A) r = c + 21'h20;
      else if (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) r = c + 21'h20;
      else if (c >= 21'h100 && c <= 21'h137 && !c[0]) r = c + 21'h1;
      else if (c >= 21'h139 && c <= 21'h148 && c[0]) r = c + 21'h1;
      else if (c >= 21'h14A && c <= 21'h177 && !c[0]) r = c + 21'h1;
      else if (c >= 21'h179 && c <= 21'h17E && c[0]) r = c + 21'h1;
      else if (c >= 21'h391 && c <= 21'h3AB && c != 21'h3A2) r = c + 21'h20;
      else if (c >= 21'h400 && c <= 21'h40F) r = c + 21'h50;
      else if (c >= 21'h410 && c <= 21'h42F) r = c + 21'h20;
      return r;
   endfunction

   // d = dit, a = dah, s = space; string read left to right
   function automatic code_type mk(input string s);
      code_type r;
      r = '0;
      r.hit = 1'b1;
      r.count = COUNT_BITS'(s.len());
      for (int j = 0; j < s.len(); j++) begin
         r.pattern[2*j +: 2] = (s[j] == "d") ? KIND_DIT :
                               (s[j] == "s") ? KIND_SPACE : KIND_DAH;
      end
      return r;
   endfunction

   function automatic code_type lookup(input logic [CHAR_BITS-1:0] c, input logic ukr);
      code_type r;
      r = '0;
      unique case (c)
         21'h20: r = mk("s");
         21'h61: r = mk("da"); 21'h62: r = mk("addd"); 21'h63: r = mk("adad");
         21'h64: r = mk("add"); 21'h65: r = mk("d"); 21'h66: r = mk("ddad");
         21'h67: r = mk("aad"); 21'h68: r = mk("dddd"); 21'h69: r = mk("dd");
         21'h6A: r = mk("daaa"); 21'h6B: r = mk("ada"); 21'h6C: r = mk("dadd");
         21'h6D: r = mk("aa"); 21'h6E: r = mk("ad"); 21'h6F: r = mk("aaa");
         21'h70: r = mk("daad"); 21'h71: r = mk("aada"); 21'h72: r = mk("dad");
         21'h73: r = mk("ddd"); 21'h74: r = mk("a"); 21'h75: r = mk("dda");
         21'h76: r = mk("ddda"); 21'h77: r = mk("daa"); 21'h78: r = mk("adda");
         21'h79: r = mk("adaa"); 21'h7A: r = mk("aadd");
         21'h30: r = mk("aaaaa"); 21'h31: r = mk("daaaa"); 21'h32: r = mk("ddaaa");
         21'h33: r = mk("dddaa"); 21'h34: r = mk("dddda"); 21'h35: r = mk("ddddd");
         21'h36: r = mk("adddd"); 21'h37: r = mk("aaddd"); 21'h38: r = mk("aaadd");
         21'h39: r = mk("aaaad");
         21'h2E: r = mk("dadada"); 21'h2C: r = mk("aaddaa"); 21'h3F: r = mk("ddaadd");
         21'h27: r = mk("daaaad"); 21'h21: r = mk("adadaa"); 21'h2F: r = mk("addad");
         21'h28: r = mk("adaad"); 21'h29: r = mk("adaada"); 21'h26: r = mk("daddd");
         21'h3A: r = mk("aaaddd"); 21'h3B: r = mk("adadad"); 21'h3D: r = mk("addda");
         21'h2B: r = mk("dadad"); 21'h2D: r = mk("adddda"); 21'h5F: r = mk("ddaada");
         21'h22: r = mk("daddad"); 21'h24: r = mk("dddadda"); 21'h40: r = mk("daadad");
         21'hE0: r = mk("daada"); 21'hE4: r = mk("dada"); 21'h105: r = mk("dada");
         21'hE6: r = mk("dada"); 21'hE5: r = mk("daada"); 21'h107: r = mk("adadd");
         21'h109: r = mk("adadd"); 21'hE7: r = mk("adadd"); 21'h111: r = mk("ddadd");
         21'hF0: r = mk("ddaad"); 21'hE9: r = mk("ddadd"); 21'h119: r = mk("ddadd");
         21'h11D: r = mk("aadad"); 21'h125: r = mk("aaaa"); 21'h135: r = mk("daaad");
         21'h142: r = mk("dadda"); 21'h144: r = mk("aadaa"); 21'hF1: r = mk("aadaa");
         21'hF3: r = mk("aaad"); 21'hF6: r = mk("aaad"); 21'hF8: r = mk("aaad");
         21'h15B: r = mk("dddaddd"); 21'h15D: r = mk("dddad"); 21'h161: r = mk("aaaa");
         21'hFE: r = mk("daadd"); 21'hFC: r = mk("ddaa"); 21'h16D: r = mk("ddaa");
         21'h17A: r = mk("aaddad"); 21'h17C: r = mk("aadda"); 21'hDF: r = mk("dddaadd");
         21'h3B1: r = mk("da"); 21'h3B2: r = mk("addd"); 21'h3B3: r = mk("aad");
         21'h3B4: r = mk("add"); 21'h3B5: r = mk("d"); 21'h3B6: r = mk("aadd");
         21'h3B7: r = mk("dddd"); 21'h3B8: r = mk("adad"); 21'h3B9: r = mk("dd");
         21'h3BA: r = mk("ada"); 21'h3BB: r = mk("dadd"); 21'h3BC: r = mk("aa");
         21'h3BD: r = mk("ad"); 21'h3BE: r = mk("adda"); 21'h3BF: r = mk("aaa");
         21'h3C0: r = mk("daad"); 21'h3C1: r = mk("dad"); 21'h3C3: r = mk("ddd");
         21'h3C2: r = mk("ddd"); 21'h3C4: r = mk("a"); 21'h3C5: r = mk("adaa");
         21'h3C6: r = mk("ddad"); 21'h3C7: r = mk("aaaa"); 21'h3C8: r = mk("aada");
         21'h3C9: r = mk("daa");
         21'h430: r = mk("da"); 21'h431: r = mk("addd"); 21'h432: r = mk("daa");
         21'h433: r = mk("aad"); 21'h434: r = mk("add"); 21'h435: r = mk("d");
         21'h436: r = mk("ddda"); 21'h437: r = mk("aadd");
         21'h438: r = ukr ? mk("adaa") : mk("dd");
         21'h439: r = mk("daaa"); 21'h43A: r = mk("ada"); 21'h43B: r = mk("dadd");
         21'h43C: r = mk("aa"); 21'h43D: r = mk("ad"); 21'h43E: r = mk("aaa");
         21'h43F: r = mk("daad"); 21'h440: r = mk("dad"); 21'h441: r = mk("ddd");
         21'h442: r = mk("a"); 21'h443: r = mk("dda"); 21'h444: r = mk("ddad");
         21'h445: r = mk("dddd"); 21'h446: r = mk("adad"); 21'h447: r = mk("aaad");
         21'h448: r = mk("aaaa"); 21'h449: r = mk("aada"); 21'h44C: r = mk("adda");
         21'h44B: r = mk("adaa"); 21'h44D: r = mk("ddadd"); 21'h44E: r = mk("ddaa");
         21'h44F: r = mk("dada"); 21'h451: r = mk("d"); 21'h454: r = mk("ddadd");
         21'h456: r = mk("dd"); 21'h457: r = mk("daaad");
         21'h5D0: r = mk("da"); 21'h5D1: r = mk("addd"); 21'h5D2: r = mk("aad");
         21'h5D3: r = mk("add"); 21'h5D4: r = mk("aaa"); 21'h5D5: r = mk("d");
         21'h5D6: r = mk("aadd"); 21'h5D7: r = mk("dddd"); 21'h5D8: r = mk("dda");
         21'h5D9: r = mk("dd"); 21'h5DA: r = mk("ada"); 21'h5DB: r = mk("ada");
         21'h5DC: r = mk("dadd"); 21'h5DD: r = mk("aa"); 21'h5DE: r = mk("aa");
         21'h5DF: r = mk("ad"); 21'h5E0: r = mk("ad"); 21'h5E1: r = mk("adad");
         21'h5E2: r = mk("daaa"); 21'h5E3: r = mk("daad"); 21'h5E4: r = mk("daad");
         21'h5E5: r = mk("daa"); 21'h5E6: r = mk("daa"); 21'h5E7: r = mk("aada");
         21'h5E8: r = mk("dad"); 21'h5E9: r = mk("ddd"); 21'h5EA: r = mk("a");
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// ===== rtl/mce_if.sv =====
// Valid/ready channel interface for the Morse character encoder.
// Depends on mce_pkg.
interface req_if;
   logic                           valid;
   logic                           ready;
   logic [mce_pkg::CHAR_BITS-1:0]  char_code;
   modport source (output valid, char_code, input ready);
   modport sink (input valid, char_code, output ready);
endinterface

interface rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      element_kind;
   logic [mce_pkg::SAMPLE_BITS-1:0] keyed_samples;
   logic [mce_pkg::SAMPLE_BITS-1:0] silent_samples;
   logic                            last_of_char;
   modport source (output valid, element_kind, keyed_samples, silent_samples, last_of_char,
                   input ready);
   modport sink (input valid, element_kind, keyed_samples, silent_samples, last_of_char,
                 output ready);
endinterface

// ===== rtl/mce_lookup.sv =====
// Registered case fold and code table lookup for the Morse encoder.
// Depends on mce_pkg.
module mce_lookup (
   input  logic                          clock,
   input  logic [mce_pkg::CHAR_BITS-1:0] char_code,
   input  logic                          ukr_i,
   output mce_pkg::code_type             code
);
   logic [mce_pkg::CHAR_BITS-1:0] folded_ff;
   mce_pkg::code_type             code_ff;

   // fold, register, then look up and register
   always_ff @(posedge clock) begin
      folded_ff <= mce_pkg::fold_case(char_code);
      code_ff <= mce_pkg::lookup(folded_ff, ukr_i);
   end

   assign code = code_ff;
endmodule

// ===== rtl/morse_character_encoder.sv =====
// Top level of the Morse character encoder: control sequencer, element shift
// register and output register. Depends on mce_pkg, mce_if and mce_lookup.
// After a request transfer the sequencer waits on the lookup, sends the
// character's elements, passes one empty send step and sends the gap, and
// only then takes the next request; a stalled response holds it.
// Reset idles the sequencer and zeroes the CSRs and control state, not output data.
module morse_character_encoder (
   input  logic        clock,
   input  logic        reset,
   req_if.sink         req,
   rsp_if.source       rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   mce_pkg::state_type state_ff, state_in;
   logic [mce_pkg::DIT_LENGTH_BITS-1:0] dit_ff;
   logic                                ukr_ff;
   logic [mce_pkg::CODE_BITS-1:0]  pattern_ff, pattern_in;
   logic [mce_pkg::COUNT_BITS-1:0] left_ff, left_in;
   logic                           wait_ff, wait_in;
   logic                           vld_ff, vld_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [mce_pkg::SAMPLE_BITS-1:0] keyed_ff, keyed_in, silent_ff, silent_in;
   logic                           last_ff, last_in;
   mce_pkg::code_type              code;
   logic [mce_pkg::SAMPLE_BITS-1:0] d1, d2, d3, d4;
   logic                           out_free;

   mce_lookup u_lookup (
      .clock(clock), .char_code(req.char_code), .ukr_i(ukr_ff), .code(code)
   );

   assign d1 = mce_pkg::SAMPLE_BITS'(dit_ff);
   assign d2 = d1 << 1;
   assign d4 = d1 << 2;
   assign d3 = d1 + d2;
   assign out_free = !vld_ff || rsp.ready;
   assign req.ready = (state_ff == mce_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mce_pkg::ST_IDLE;
         dit_ff <= '0;
         ukr_ff <= 1'b0;
         vld_ff <= 1'b0;
         pattern_ff <= '0;
         left_ff <= '0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
         pattern_ff <= pattern_in;
         left_ff <= left_in;
         wait_ff <= wait_in;
         if (csr_write) begin
            unique case (mce_pkg::csr_index_type'(csr_index))
               mce_pkg::CSR_DIT_LENGTH: dit_ff <= csr_data;
               mce_pkg::CSR_UKR_I: ukr_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      keyed_ff <= keyed_in;
      silent_ff <= silent_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      pattern_in = pattern_ff;
      left_in = left_ff;
      wait_in = wait_ff;
      vld_in = vld_ff && !rsp.ready;
      kind_in = kind_ff;
      keyed_in = keyed_ff;
      silent_in = silent_ff;
      last_in = last_ff;
      unique case (state_ff)
         mce_pkg::ST_IDLE: begin
            wait_in = 1'b0;
            if (req.valid && dit_ff != '0) state_in = mce_pkg::ST_LOAD;
         end
         mce_pkg::ST_LOAD: begin
            // wait through the fold and lookup registers of mce_lookup
            wait_in = 1'b1;
            if (wait_ff) begin
               pattern_in = code.pattern;
               left_in = code.count;
               state_in = code.hit ? mce_pkg::ST_SEND : mce_pkg::ST_IDLE;
            end
         end
         mce_pkg::ST_SEND: begin
            if (out_free) begin
               if (left_ff == '0) begin
                  state_in = mce_pkg::ST_GAP;
               end else begin
                  vld_in = 1'b1;
                  kind_in = pattern_ff[1:0];
                  last_in = 1'b0;
                  unique case (mce_pkg::kind_type'(pattern_ff[1:0]))
                     mce_pkg::KIND_DIT: begin keyed_in = d1; silent_in = d1; end
                     mce_pkg::KIND_DAH: begin keyed_in = d3; silent_in = d1; end
                     default: begin keyed_in = '0; silent_in = d4; end
                  endcase
                  pattern_in = pattern_ff >> 2;
                  left_in = left_ff - 1'b1;
               end
            end
         end
         mce_pkg::ST_GAP: begin
            if (out_free) begin
               vld_in = 1'b1;
               kind_in = mce_pkg::KIND_GAP;
               keyed_in = '0;
               silent_in = d2;
               last_in = 1'b1;
               state_in = mce_pkg::ST_IDLE;
            end
         end
         default: state_in = mce_pkg::ST_IDLE;
      endcase
   end

   assign rsp.valid = vld_ff;
   assign rsp.element_kind = kind_ff;
   assign rsp.keyed_samples = keyed_ff;
   assign rsp.silent_samples = silent_ff;
   assign rsp.last_of_char = last_ff;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp.ready |=> vld_ff && $stable(kind_ff))
      else $error("response dropped");
   a_gap_last: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (kind_ff == mce_pkg::KIND_GAP) == last_ff)
      else $error("last flag mismatch");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mce_pkg::ST_GAP |-> left_ff == '0)
      else $error("elements left at gap");
`endif
endmodule

// ===== tb/sv/tb_morse_character_encoder.sv =====
`timescale 1ns / 1ps
// Testbench for the Morse character encoder: drives characters, checks each
// response element against a local code table and case fold. Depends on mce_pkg,
// mce_if and the encoder RTL.
module tb_morse_character_encoder;
   typedef struct packed {
      logic [1:0]  kind;
      logic [17:0] keyed;
      logic [17:0] silent;
      logic        last;
   } element_type;

   typedef struct {
      logic [20:0] ch;
      int          has_expect;
      element_type first_elem;
   } vector_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic csr_index;
   logic [15:0] csr_data;

   req_if req ();
   rsp_if rsp ();

   morse_character_encoder i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   element_type expected_elements[$];
   logic [15:0] dit_len;
   logic        ukr_variant;
   int          errors;
   int          idle_cycles;
   int          send_idle_pct;
   int          stall_pct;
   int          first_check;
   element_type first_value;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input element_type got,
                                  input element_type want);
      $display("mismatch %s: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d", what,
               got.kind, got.keyed, got.silent, got.last,
               want.kind, want.keyed, want.silent, want.last);
      errors++;
   endtask

   function automatic string morse_of(input logic [20:0] c);
      case (c)
         21'h20: return " ";
         21'h61: return "._"; 21'h62: return "_..."; 21'h63: return "_._.";
         21'h64: return "_.."; 21'h65: return "."; 21'h66: return ".._.";
         21'h67: return "__."; 21'h68: return "...."; 21'h69: return "..";
         21'h6A: return ".___"; 21'h6B: return "_._"; 21'h6C: return "._..";
         21'h6D: return "__"; 21'h6E: return "_."; 21'h6F: return "___";
         21'h70: return ".__."; 21'h71: return "__._"; 21'h72: return "._.";
         21'h73: return "..."; 21'h74: return "_"; 21'h75: return ".._";
         21'h76: return "..._"; 21'h77: return ".__"; 21'h78: return "_.._";
         21'h79: return "_.__"; 21'h7A: return "__..";
         21'h30: return "_____"; 21'h31: return ".____"; 21'h32: return "..___";
         21'h33: return "...__"; 21'h34: return "...._"; 21'h35: return ".....";
         21'h36: return "_...."; 21'h37: return "__..."; 21'h38: return "___..";
         21'h39: return "____.";
         21'h2E: return "._._._"; 21'h2C: return "__..__"; 21'h3F: return "..__..";
         21'h27: return ".____."; 21'h21: return "_._.__"; 21'h2F: return "_.._.";
         21'h28: return "_.__."; 21'h29: return "_.__._"; 21'h26: return "._...";
         21'h3A: return "___..."; 21'h3B: return "_._._."; 21'h3D: return "_..._";
         21'h2B: return "._._."; 21'h2D: return "_...._"; 21'h5F: return "..__._";
         21'h22: return "._.._."; 21'h24: return "..._.._"; 21'h40: return ".__._.";
         21'hE0: return ".__._"; 21'hE4: return "._._"; 21'h105: return "._._";
         21'hE6: return "._._"; 21'hE5: return ".__._"; 21'h107: return "_._..";
         21'h109: return "_._.."; 21'hE7: return "_._.."; 21'h111: return ".._..";
         21'hF0: return "..__."; 21'hE9: return ".._.."; 21'h119: return ".._..";
         21'h11D: return "__._."; 21'h125: return "____"; 21'h135: return ".___.";
         21'h142: return "._.._"; 21'h144: return "__.__"; 21'hF1: return "__.__";
         21'hF3: return "___."; 21'hF6: return "___."; 21'hF8: return "___.";
         21'h15B: return "..._..."; 21'h15D: return "..._."; 21'h161: return "____";
         21'hFE: return ".__.."; 21'hFC: return "..__"; 21'h16D: return "..__";
         21'h17A: return "__.._."; 21'h17C: return "__.._"; 21'hDF: return "...__..";
         21'h3B1: return "._"; 21'h3B2: return "_..."; 21'h3B3: return "__.";
         21'h3B4: return "_.."; 21'h3B5: return "."; 21'h3B6: return "__..";
         21'h3B7: return "...."; 21'h3B8: return "_._."; 21'h3B9: return "..";
         21'h3BA: return "_._"; 21'h3BB: return "._.."; 21'h3BC: return "__";
         21'h3BD: return "_."; 21'h3BE: return "_.._"; 21'h3BF: return "___";
         21'h3C0: return ".__."; 21'h3C1: return "._."; 21'h3C3: return "...";
         21'h3C2: return "..."; 21'h3C4: return "_"; 21'h3C5: return "_.__";
         21'h3C6: return ".._."; 21'h3C7: return "____"; 21'h3C8: return "__._";
         21'h3C9: return ".__";
         21'h430: return "._"; 21'h431: return "_..."; 21'h432: return ".__";
         21'h433: return "__."; 21'h434: return "_.."; 21'h435: return ".";
         21'h436: return "..._"; 21'h437: return "__..";
         21'h438: return ukr_variant ? "_.__" : "..";
         21'h439: return ".___"; 21'h43A: return "_._"; 21'h43B: return "._..";
         21'h43C: return "__"; 21'h43D: return "_."; 21'h43E: return "___";
         21'h43F: return ".__."; 21'h440: return "._."; 21'h441: return "...";
         21'h442: return "_"; 21'h443: return ".._"; 21'h444: return ".._.";
         21'h445: return "...."; 21'h446: return "_._."; 21'h447: return "___.";
         21'h448: return "____"; 21'h449: return "__._"; 21'h44C: return "_.._";
         21'h44B: return "_.__"; 21'h44D: return ".._.."; 21'h44E: return "..__";
         21'h44F: return "._._"; 21'h451: return "."; 21'h454: return ".._..";
         21'h456: return ".."; 21'h457: return ".___.";
         21'h5D0: return "._"; 21'h5D1: return "_..."; 21'h5D2: return "__.";
         21'h5D3: return "_.."; 21'h5D4: return "___"; 21'h5D5: return ".";
         21'h5D6: return "__.."; 21'h5D7: return "...."; 21'h5D8: return ".._";
         21'h5D9: return ".."; 21'h5DA: return "_._"; 21'h5DB: return "_._";
         21'h5DC: return "._.."; 21'h5DD: return "__"; 21'h5DE: return "__";
         21'h5DF: return "_."; 21'h5E0: return "_."; 21'h5E1: return "_._.";
         21'h5E2: return ".___"; 21'h5E3: return ".__."; 21'h5E4: return ".__.";
         21'h5E5: return ".__"; 21'h5E6: return ".__"; 21'h5E7: return "__._";
         21'h5E8: return "._."; 21'h5E9: return "..."; 21'h5EA: return "_";
         default: return "";
      endcase
   endfunction

   function automatic logic [20:0] to_lower(input logic [20:0] c);
      if (c == 21'h130) return 21'h69;
      if (c == 21'h212A) return 21'h6B;
      if (c == 21'h212B) return 21'hE5;
      if (c == 21'h2126) return 21'h3C9;
      if (c >= 21'h41 && c <= 21'h5A) return c + 21'h20;
      if (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) return c + 21'h20;
      if (c >= 21'h100 && c <= 21'h137 && !c[0]) return c + 21'h1;
      if (c >= 21'h139 && c <= 21'h148 && c[0]) return c + 21'h1;
      if (c >= 21'h14A && c <= 21'h177 && !c[0]) return c + 21'h1;
      if (c >= 21'h179 && c <= 21'h17E && c[0]) return c + 21'h1;
      if (c >= 21'h391 && c <= 21'h3AB && c != 21'h3A2) return c + 21'h20;
      if (c >= 21'h400 && c <= 21'h40F) return c + 21'h50;
      if (c >= 21'h410 && c <= 21'h42F) return c + 21'h20;
      return c;
   endfunction

   task automatic key_character(input logic [20:0] c);
      string       code;
      element_type e;
      logic [17:0] d;
      d = 18'(dit_len);
      code = morse_of(to_lower(c));
      if (dit_len == 0 || code.len() == 0) return;
      for (int j = 0; j < code.len() && j < 7; j++) begin
         if (code[j] == ".") e = '{mce_pkg::KIND_DIT, d, d, 1'b0};
         else if (code[j] == " ") e = '{mce_pkg::KIND_SPACE, 18'd0, 18'(4 * d), 1'b0};
         else e = '{mce_pkg::KIND_DAH, 18'(3 * d), d, 1'b0};
         expected_elements.push_back(e);
      end
      expected_elements.push_back('{mce_pkg::KIND_GAP, 18'd0, 18'(2 * d), 1'b1});
   endtask

   task automatic write_csr(input mce_pkg::csr_index_type idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == mce_pkg::CSR_DIT_LENGTH) dit_len = value;
      else ukr_variant = value[0];
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_elements.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // hold valid after the transfer; the next send or drain drives it again
   task automatic send_character(input logic [20:0] c);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.char_code <= c;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      key_character(c);
   endtask

   function automatic logic [20:0] random_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return 21'(8'h20 + $urandom_range(8'h5F));
      if (pick < 45) return 21'(9'hC0 + $urandom_range(9'hBF));
      if (pick < 60) return 21'(11'h390 + $urandom_range(11'h3F));
      if (pick < 75) return 21'(11'h400 + $urandom_range(11'h5F));
      if (pick < 85) return 21'(11'h5D0 + $urandom_range(11'h1F));
      if (pick < 90) return 21'(14'h2126 + $urandom_range(5));
      return 21'($urandom_range(21'h1FFFFF));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         element_type got;
         got = '{rsp.element_kind, rsp.keyed_samples, rsp.silent_samples, rsp.last_of_char};
         if (expected_elements.size() == 0) begin
            report_mismatch("unexpected", got, '0);
         end else begin
            if (got !== expected_elements[0]) report_mismatch("element", got, expected_elements[0]);
            if (first_check) begin
               if (got !== first_value) report_mismatch("directed", got, first_value);
               first_check = 0;
            end
            void'(expected_elements.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   vector_type directed[] = '{
      '{21'h65, 1, '{mce_pkg::KIND_DIT, 18'd1, 18'd1, 1'b0}},
      '{21'h54, 1, '{mce_pkg::KIND_DAH, 18'd3, 18'd1, 1'b0}},
      '{21'h20, 1, '{mce_pkg::KIND_SPACE, 18'd0, 18'd4, 1'b0}},
      '{21'h1FFFFF, 0, '0}, '{21'h0, 0, '0}, '{21'h24, 0, '0}, '{21'hDF, 0, '0},
      '{21'h15A, 0, '0}, '{21'h130, 0, '0}, '{21'h212A, 0, '0}, '{21'h212B, 0, '0},
      '{21'h2126, 0, '0}, '{21'h418, 0, '0}, '{21'h438, 0, '0}, '{21'h407, 0, '0},
      '{21'h393, 0, '0}, '{21'hC4, 0, '0}, '{21'hD7, 0, '0}, '{21'h5EA, 0, '0},
      '{21'h3A2, 0, '0}, '{21'h110000, 0, '0}, '{21'h30, 0, '0}
   };

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      req.valid = 1'b0;
      req.char_code = '0;
      dit_len = '0;
      ukr_variant = 1'b0;
      errors = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      first_check = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // no output before dit length is set
      send_character(21'h65);
      drain();
      write_csr(mce_pkg::CSR_DIT_LENGTH, 16'd1);
      foreach (directed[i]) begin
         if (directed[i].has_expect) begin
            first_value = directed[i].first_elem;
            first_check = 1;
         end
         send_character(directed[i].ch);
         drain();
      end
      write_csr(mce_pkg::CSR_UKR_I, 16'd1);
      write_csr(mce_pkg::CSR_DIT_LENGTH, 16'hFFFF);
      send_character(21'h438);
      send_character(21'h15B);
      send_character(21'h20);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 8 : 0;
         stall_pct = (ph == 2) ? 50 : (ph == 3) ? 8 : 0;
         write_csr(mce_pkg::CSR_UKR_I, 16'($urandom_range(1)));
         write_csr(mce_pkg::CSR_DIT_LENGTH,
                   (ph == 0) ? 16'hFFFF : 16'($urandom_range(16'hFFFF)));
         for (int k = 0; k < 24; k++) send_character(random_char());
         drain();
      end
      // drop dit length to zero mid run
      write_csr(mce_pkg::CSR_DIT_LENGTH, 16'd0);
      send_character(21'h61);
      drain();
      if (errors == 0 && expected_elements.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
